/* src/ipd_http_request_classifier_top_assert.svh */
// Assertion macros for the classifier's top-level RTL file.
`ifndef IPD_HTTP_REQUEST_CLASSIFIER_TOP_ASSERT_SVH
`define IPD_HTTP_REQUEST_CLASSIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPDHRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPDHRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ipdhrc_pkg.sv */
// Constants, types and helper functions of the HTTP request classifier.
package ipdhrc_pkg;

    localparam int LINE_MAX   = 512;
    localparam int LINE_LIMIT = LINE_MAX - 6;
    localparam int LEN_W      = $clog2(LINE_LIMIT + 1);

    localparam logic [39:0] PREFIX_WORD = "+IPD,";
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [7:0]  CHAR_PLUS   = "+";
    localparam logic [7:0]  CHAR_MINUS  = "-";
    localparam logic [7:0]  CHAR_AMP    = "&";
    localparam logic [7:0]  CHAR_SPACE  = " ";
    localparam logic [7:0]  CHAR_ZERO   = "0";
    localparam logic [7:0]  CHAR_NINE   = "9";
    localparam logic [7:0]  CHAR_TAB    = 8'h09;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;

    localparam logic [0:15][7:0] PAT_HOME = {"GET / ", 80'h0};
    localparam logic [0:15][7:0] PAT_HIST = {"GET /historial", 16'h0};
    localparam logic [0:15][7:0] PAT_SET  = {"GET /set?alto=", 16'h0};
    localparam logic [3:0]       LEN_HOME = 4'd6;
    localparam logic [3:0]       LEN_HIST = 4'd14;
    localparam logic [3:0]       LEN_SET  = 4'd14;
    localparam logic [0:4][7:0]  LIT_BAJO = "bajo=";

    localparam logic [15:0] MAG_CAP = 16'h8000;

    // Number parser phases, one-hot.
    typedef enum logic [12:0] {
        PH_IDLE   = 13'b0000000000001,
        PH_A_PRE  = 13'b0000000000010,
        PH_A_SIGN = 13'b0000000000100,
        PH_A_DIG  = 13'b0000000001000,
        PH_LIT0   = 13'b0000000010000,
        PH_LIT1   = 13'b0000000100000,
        PH_LIT2   = 13'b0000001000000,
        PH_LIT3   = 13'b0000010000000,
        PH_LIT4   = 13'b0000100000000,
        PH_B_PRE  = 13'b0001000000000,
        PH_B_SIGN = 13'b0010000000000,
        PH_B_DIG  = 13'b0100000000000,
        PH_DONE   = 13'b1000000000000
    } parse_phase_t;

    // Control from the line tracker to the number parser.
    typedef struct packed {
        logic clear;  // line ends or starts: drop all parse state
        logic step;   // an ordinary line byte is to be parsed
        logic start;  // first set match in this line completed on this byte
    } parse_ctl_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] pos;
    } match_res_t;

    function automatic match_res_t match_step(input logic [0:15][7:0] pat,
                                              input logic [3:0] len,
                                              input logic [3:0] pos,
                                              input logic [7:0] c);
        match_res_t r;
        logic [3:0] p1;
        p1 = pos + 4'd1;
        r.hit = 1'b0;
        r.pos = 4'd0;
        if ((pos < len) && (c == pat[pos])) begin
            if (p1 >= len) begin
                r.hit = 1'b1;
            end else begin
                r.pos = p1;
            end
        end else if (c == pat[0]) begin
            r.pos = 4'd1;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Decimal digit accumulation, capped at 32768.
    function automatic logic [15:0] add_digit(input logic [15:0] m, input logic [7:0] c);
        logic [19:0] t;
        t = ({4'd0, m} << 3) + ({4'd0, m} << 1) + {16'd0, c[3:0]};
        return (t > {4'd0, MAG_CAP}) ? MAG_CAP : t[15:0];
    endfunction

    function automatic logic signed [15:0] to_field(input logic [15:0] mag, input logic neg);
        logic [15:0] v;
        if (neg) begin
            v = 16'd0 - mag;
        end else begin
            v = (mag > 16'h7FFF) ? 16'h7FFF : mag;
        end
        return signed'(v);
    endfunction

endpackage

/* src/ipdhrc_num_parse.sv */
// Parser for the two signed decimals that follow the first set request match.
module ipdhrc_num_parse (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipdhrc_pkg::parse_ctl_t  ctl,
    input  logic [7:0]              rx_byte,
    output logic signed [15:0]      high_value,
    output logic signed [15:0]      low_value
);
    import ipdhrc_pkg::*;

    parse_phase_t phase_reg, phase_next;
    logic [15:0]  high_reg, high_next;
    logic [15:0]  low_reg, low_next;
    logic [1:0]   sign_reg, sign_next;

    logic digit;
    logic space;

    assign digit = is_digit(rx_byte);
    assign space = is_space(rx_byte);

    always_comb begin
        phase_next = phase_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        sign_next  = sign_reg;
        case (phase_reg)
            PH_A_PRE, PH_A_SIGN: begin
                if ((phase_reg == PH_A_PRE) && space) begin
                    phase_next = phase_reg;
                end else if ((phase_reg == PH_A_PRE)
                             && ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS))) begin
                    sign_next[0] = sign_reg[0] | (rx_byte == CHAR_MINUS);
                    phase_next   = PH_A_SIGN;
                end else if (digit) begin
                    high_next  = add_digit(high_reg, rx_byte);
                    phase_next = PH_A_DIG;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_A_DIG: begin
                if (digit) begin
                    high_next = add_digit(high_reg, rx_byte);
                end else if (rx_byte == CHAR_AMP) begin
                    phase_next = PH_LIT0;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_LIT0: phase_next = (rx_byte == LIT_BAJO[0]) ? PH_LIT1  : PH_DONE;
            PH_LIT1: phase_next = (rx_byte == LIT_BAJO[1]) ? PH_LIT2  : PH_DONE;
            PH_LIT2: phase_next = (rx_byte == LIT_BAJO[2]) ? PH_LIT3  : PH_DONE;
            PH_LIT3: phase_next = (rx_byte == LIT_BAJO[3]) ? PH_LIT4  : PH_DONE;
            PH_LIT4: phase_next = (rx_byte == LIT_BAJO[4]) ? PH_B_PRE : PH_DONE;
            PH_B_PRE, PH_B_SIGN: begin
                if ((phase_reg == PH_B_PRE) && space) begin
                    phase_next = phase_reg;
                end else if ((phase_reg == PH_B_PRE)
                             && ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS))) begin
                    sign_next[1] = sign_reg[1] | (rx_byte == CHAR_MINUS);
                    phase_next   = PH_B_SIGN;
                end else if (digit) begin
                    low_next   = add_digit(low_reg, rx_byte);
                    phase_next = PH_B_DIG;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_B_DIG: begin
                if (digit) begin
                    low_next = add_digit(low_reg, rx_byte);
                end else begin
                    phase_next = PH_DONE;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            high_reg  <= '0;
            low_reg   <= '0;
            sign_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            phase_reg <= PH_IDLE;
            high_reg  <= '0;
            low_reg   <= '0;
            sign_reg  <= '0;
        end
        else if (ctl.start)
        begin
            // The parser is idle before the first set match, so only the phase moves.
            phase_reg <= PH_A_PRE;
        end
        else if (ctl.step)
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            sign_reg  <= sign_next;
        end
    end

    assign high_value = to_field(high_reg, sign_reg[0]);
    assign low_value  = to_field(low_reg, sign_reg[1]);

endmodule

/* src/ipd_http_request_classifier_top.sv */
// Top level of the HTTP request classifier for a wireless module's serial stream.
//
//   Channel  | Dir | Signals                      | Carries
//   ---------+-----+------------------------------+----------------------------------
//   s        | in  | s_tvalid s_tready s_tdata    | one received byte per item
//   m        | out | m_tvalid m_tready m_tdata    | one classification per request line
//            |     | m_tuser                      |
//
// Each byte is held in the input register and is then classified by the matchers and the
// number parser in a single pass, so the block takes one item every cycle while m holds back no item.
// A line-ending newline moves from the input register into the result register;
// other bytes give no item on m. The input only stalls while m holds back a waiting item.
// Reset (rst_n low, asynchronous) clears the window, the line state and both valid flags,
// and the block is ready to accept items as soon as reset is released.
`include "ipd_http_request_classifier_top_assert.svh"

module ipd_http_request_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] connection_id, [23:8] high_value,
                                   // [39:24] low_value
    output logic [2:0]  m_tuser    // [0] home_request, [1] history_request, [2] set_request
);
    import ipdhrc_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Line tracking state.
    logic [39:0]      window_reg;
    logic [39:0]      window_next;
    logic             in_line_reg;
    logic [LEN_W-1:0] line_len_reg;
    logic [7:0]       captured_id_reg;
    logic [2:0]       home_pos_reg;
    logic [3:0]       hist_pos_reg;
    logic [3:0]       set_pos_reg;
    logic [2:0]       found_reg;

    // Result register.
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic [2:0]  out_user_reg;

    logic       advance;
    logic       prefix_hit;
    logic       len_full;
    logic       line_byte;
    logic       is_lf;
    logic       emit;
    logic       clear_line;
    logic       step;
    logic [7:0] id_now;

    match_res_t home_res;
    match_res_t hist_res;
    match_res_t set_res;
    parse_ctl_t pctl;

    logic signed [15:0] high_value;
    logic signed [15:0] low_value;

    // A byte moves on whenever the result register is free or is being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign window_next = {window_reg[31:0], in_byte_reg};
    assign prefix_hit  = (window_next == PREFIX_WORD);
    assign len_full    = (line_len_reg >= LEN_W'(LINE_LIMIT));
    assign line_byte   = in_line_reg && !len_full;
    assign is_lf       = (in_byte_reg == CHAR_LF);
    assign emit        = advance && line_byte && is_lf;
    assign step        = advance && line_byte && !is_lf;
    assign clear_line  = advance && (in_line_reg ? (len_full || is_lf) : prefix_hit);

    // The first byte of a line is the connection id, even when it is the newline.
    assign id_now = (line_len_reg == '0) ? in_byte_reg : captured_id_reg;

    assign home_res = match_step(PAT_HOME, LEN_HOME, {1'b0, home_pos_reg}, in_byte_reg);
    assign hist_res = match_step(PAT_HIST, LEN_HIST, hist_pos_reg, in_byte_reg);
    assign set_res  = match_step(PAT_SET, LEN_SET, set_pos_reg, in_byte_reg);

    assign pctl.clear = clear_line;
    assign pctl.step  = step;
    assign pctl.start = step && set_res.hit && !found_reg[2];

    ipdhrc_num_parse u_num_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pctl),
        .rx_byte    (in_byte_reg),
        .high_value (high_value),
        .low_value  (low_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            in_line_reg     <= 1'b0;
            line_len_reg    <= '0;
            captured_id_reg <= '0;
            home_pos_reg    <= '0;
            hist_pos_reg    <= '0;
            set_pos_reg     <= '0;
            found_reg       <= '0;
        end
        else if (advance)
        begin
            window_reg <= window_next;
            if (clear_line)
            begin
                in_line_reg     <= !in_line_reg;
                line_len_reg    <= '0;
                captured_id_reg <= '0;
                home_pos_reg    <= '0;
                hist_pos_reg    <= '0;
                set_pos_reg     <= '0;
                found_reg       <= '0;
            end
            else if (step)
            begin
                line_len_reg    <= line_len_reg + LEN_W'(1);
                captured_id_reg <= id_now;
                home_pos_reg    <= home_res.pos[2:0];
                hist_pos_reg    <= hist_res.pos;
                set_pos_reg     <= set_res.pos;
                found_reg       <= found_reg | {set_res.hit, hist_res.hit, home_res.hit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg[7:0]   <= id_now;
            out_data_reg[23:8]  <= found_reg[2] ? high_value : 16'sd0;
            out_data_reg[39:24] <= found_reg[2] ? low_value : 16'sd0;
            out_user_reg        <= {found_reg[2], found_reg[1], found_reg[0] | found_reg[2]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // A set request always counts as a home request.
    `IPDHRC_ASSERT_NOW(a_set_implies_home, m_tvalid && m_tuser[2], m_tuser[0],
        "set request without home flag")
    // Without a set request both numbers are zero.
    `IPDHRC_ASSERT_NOW(a_values_zero_without_set, m_tvalid && !m_tuser[2],
        m_tdata[39:8] == 32'd0, "numbers present without a set request")
    // Outside a line the length counter stays cleared.
    `IPDHRC_ASSERT_NOW(a_len_clear_outside_line, !in_line_reg, line_len_reg == '0,
        "line length nonzero while searching for the prefix")
    // A newline that ends a line always loads the result register.
    `IPDHRC_ASSERT_NEXT(a_newline_gives_result, emit, out_valid_reg,
        "newline did not produce a result")

endmodule
